[design/note_on_off_pairing_defines.svh]
// ----------------------------------------------------------------------------
// Note pairing assertion macros
// Concurrent assertion helpers used by the note on/off pairing module.
// ----------------------------------------------------------------------------
`ifndef NOTE_ON_OFF_PAIRING_DEFINES_SVH
`define NOTE_ON_OFF_PAIRING_DEFINES_SVH

`ifndef ASSERT_OFF
`define NOPP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("note pairing assertion failed");
`define NOPP_ASSERT_NEVER(label, expr) \
    `NOPP_ASSERT(label, !(expr))
`else
`define NOPP_ASSERT(label, prop)
`define NOPP_ASSERT_NEVER(label, expr)
`endif

`endif

[design/nopp_pkg.sv]
// ----------------------------------------------------------------------------
// Note pairing package
// Sizes, codes and request/response types of the note on/off pairing block.
// ----------------------------------------------------------------------------
package nopp_pkg;

    localparam int NUM_NOTES   = 128;
    localparam int STACK_DEPTH = 8;
    localparam int ID_WIDTH    = 16;

    localparam int NOTE_W   = 7;
    localparam int EXT_ID_W = 16;

    localparam int NOTE_AW     = (NUM_NOTES > 1) ? $clog2(NUM_NOTES) : 1;
    localparam int TOP_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int STK_ENTRIES = NUM_NOTES * STACK_DEPTH;
    localparam int STK_AW      = (STK_ENTRIES > 1) ? $clog2(STK_ENTRIES) : 1;

    typedef enum logic [1:0] {
        FN_OTHER = 2'd0,
        FN_ON    = 2'd1,
        FN_OFF   = 2'd2,
        FN_END   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_PAIR      = 2'd1,
        ST_UNMATCHED = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_META,
        S_STACK,
        S_OUT
    } state_t;

    typedef struct packed {
        func_t                func;
        logic                 already_paired;
        logic [NOTE_W-1:0]    note;
        logic [EXT_ID_W-1:0]  event_id;
    } pair_req_t;

    typedef struct packed {
        status_t              status;
        logic [EXT_ID_W-1:0]  on_id;
        logic [EXT_ID_W-1:0]  off_id;
    } pair_rsp_t;

    typedef struct packed {
        logic [TOP_W-1:0] top;
        logic [CNT_W-1:0] count;
    } note_meta_t;

    typedef struct packed {
        logic               wr_en;
        logic               clear_all;
        logic [NOTE_AW-1:0] note;
        note_meta_t         meta;
    } meta_wr_t;

endpackage

[design/note_on_off_pairing.sv]
// ----------------------------------------------------------------------------
// Note on/off pairing
// Pairs note-on and note-off events of one channel using a stack per note.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_valid/req_stall/req_data, one event each, in time
// order. Every request yields exactly one response on rsp_valid/rsp_stall/
// rsp_data: a pair, an unmatched note-off, a push overflow or nothing.
// A request is taken when req_valid is high and req_stall is low; the block
// stalls its input while a request is in progress.
// Each request passes through the per-note table read, the stack memory
// read and the write-back, and its response is then loaded into the output
// register; a new request is taken only after that load.
// A finished response waits in the output register while rsp_stall is high;
// the next request is then held off until the response can be loaded.
// Reset empties every stack at once through per-note valid bits; no clearing
// pass is needed and requests are taken from the first cycle after reset.
// An end-of-list request empties all stacks in the same way.
// ----------------------------------------------------------------------------
module note_on_off_pairing (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  nopp_pkg::pair_req_t   req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output nopp_pkg::pair_rsp_t   rsp_data
);
    import nopp_pkg::*;

`include "note_on_off_pairing_defines.svh"

    localparam logic [NOTE_W:0]  NOTE_LIMIT = (NOTE_W + 1)'(NUM_NOTES);
    localparam logic [TOP_W-1:0] TOP_LAST   = TOP_W'(STACK_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(STACK_DEPTH);

    state_t              state_reg, state_next;
    pair_req_t           req_reg;
    note_meta_t          meta_reg;
    logic [TOP_W-1:0]    top_sel_reg;
    logic [STK_AW-1:0]   stk_addr_reg;
    logic [ID_WIDTH-1:0] stack_mem [STK_ENTRIES];
    logic [ID_WIDTH-1:0] stack_rd_reg;
    pair_rsp_t           res_reg;
    pair_rsp_t           rsp_reg;
    logic                rsp_valid_reg;

    logic                accept;
    logic                load_ok;
    logic                is_active;
    logic [NOTE_AW-1:0]  note_idx;
    note_meta_t          tbl_meta;
    meta_wr_t            tbl_wr;
    logic [TOP_W-1:0]    top_dec;
    logic [TOP_W-1:0]    top_sel;
    logic [TOP_W-1:0]    top_inc;
    logic [STK_AW-1:0]   stk_addr;
    logic [ID_WIDTH-1:0] id_keep;
    logic                stack_wr;
    logic                full;
    pair_rsp_t           res_next;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign load_ok   = !rsp_valid_reg || !rsp_stall;
    assign note_idx  = req_reg.note[NOTE_AW-1:0];
    assign id_keep   = ID_WIDTH'(req_reg.event_id);
    assign is_active = ((req_reg.func == FN_ON) || (req_reg.func == FN_OFF))
                       && !req_reg.already_paired
                       && ({1'b0, req_reg.note} < NOTE_LIMIT);

    nopp_note_table u_note_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_note (req_data.note[NOTE_AW-1:0]),
        .rd_meta (tbl_meta),
        .wr      (tbl_wr)
    );

    // A pop reads the slot below the top; a push reads the slot it will
    // overwrite, which is the oldest entry when the stack is full.
    always_comb
    begin
        top_dec  = (tbl_meta.top == '0) ? TOP_LAST : tbl_meta.top - 1'b1;
        top_sel  = (req_reg.func == FN_OFF) ? top_dec : tbl_meta.top;
        stk_addr = STK_AW'(note_idx) * STK_AW'(STACK_DEPTH) + STK_AW'(top_sel);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_data;
        end
        if (state_reg == S_META)
        begin
            meta_reg     <= tbl_meta;
            top_sel_reg  <= top_sel;
            stk_addr_reg <= stk_addr;
            stack_rd_reg <= stack_mem[stk_addr];
        end
        if (stack_wr)
        begin
            stack_mem[stk_addr_reg] <= id_keep;
        end
        if (state_reg == S_STACK)
        begin
            res_reg <= res_next;
        end
        if ((state_reg == S_OUT) && load_ok)
        begin
            rsp_reg <= res_reg;
        end
    end

    always_comb
    begin
        top_inc          = (top_sel_reg == TOP_LAST) ? '0 : top_sel_reg + 1'b1;
        full             = (meta_reg.count == CNT_FULL);
        stack_wr         = 1'b0;
        tbl_wr           = '0;
        tbl_wr.note      = note_idx;
        tbl_wr.meta      = meta_reg;
        res_next         = '0;
        res_next.status  = ST_NONE;
        if (state_reg == S_STACK)
        begin
            tbl_wr.clear_all = (req_reg.func == FN_END);
            tbl_wr.wr_en     = is_active;
            if (is_active && (req_reg.func == FN_ON))
            begin
                stack_wr        = 1'b1;
                tbl_wr.meta.top = top_inc;
                if (full)
                begin
                    res_next.status = ST_OVERFLOW;
                    res_next.on_id  = EXT_ID_W'(stack_rd_reg);
                end
                else
                begin
                    tbl_wr.meta.count = meta_reg.count + 1'b1;
                end
            end
            else if (is_active)
            begin
                res_next.off_id = EXT_ID_W'(id_keep);
                if (meta_reg.count != '0)
                begin
                    tbl_wr.meta.top   = top_sel_reg;
                    tbl_wr.meta.count = meta_reg.count - 1'b1;
                    res_next.status   = ST_PAIR;
                    res_next.on_id    = EXT_ID_W'(stack_rd_reg);
                end
                else
                begin
                    res_next.status = ST_UNMATCHED;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_META;
                end
            end
            S_META:  state_next = S_STACK;
            S_STACK: state_next = S_OUT;
            S_OUT:
            begin
                if (load_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_OUT) && load_ok)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    `NOPP_ASSERT(a_accept_reads_meta, accept |=> state_reg == S_META)
    `NOPP_ASSERT(a_count_in_range, state_reg == S_STACK |-> meta_reg.count <= CNT_FULL)
    `NOPP_ASSERT(a_rsp_from_out, $rose(rsp_valid_reg) |-> $past(state_reg == S_OUT))
    `NOPP_ASSERT_NEVER(a_unmatched_has_on, res_next.status == ST_UNMATCHED && |res_next.on_id)
    `NOPP_ASSERT_NEVER(a_write_outside_stack, (tbl_wr.wr_en || stack_wr) && state_reg != S_STACK)

endmodule

[design/nopp_note_table.sv]
// ----------------------------------------------------------------------------
// Note pairing per-note table
// Holds the top slot and entry count of every note's stack in a synchronous
// memory, with one valid bit per note so that a clear empties all at once.
// ----------------------------------------------------------------------------
module nopp_note_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [nopp_pkg::NOTE_AW-1:0]  rd_note,
    output nopp_pkg::note_meta_t          rd_meta,
    input  nopp_pkg::meta_wr_t            wr
);
    import nopp_pkg::*;

    note_meta_t           meta_mem [NUM_NOTES];
    logic [NUM_NOTES-1:0] vld_reg;
    note_meta_t           rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            meta_mem[wr.note] <= wr.meta;
        end
        if (rd_en)
        begin
            rd_data_reg <= meta_mem[rd_note];
        end
    end

    // A note that has not been written since the last clear reads as empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.clear_all)
            begin
                vld_reg <= '0;
            end
            else if (wr.wr_en)
            begin
                vld_reg[wr.note] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_note];
            end
        end
    end

    assign rd_meta = rd_vld_reg ? rd_data_reg : '0;

endmodule
